### rtl/core/tlpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpd_pkg: shared types and constants of the typed length-prefix deframer
// Header type codes, the raw-run code, the result record and the depth of
// the result queue.
// ----------------------------------------------------------------------------
package tlpd_pkg;

  localparam logic [7:0] TYPE_SHORT_A = 8'hC1;
  localparam logic [7:0] TYPE_LONG_A  = 8'hC2;
  localparam logic [7:0] TYPE_SHORT_B = 8'hC3;
  localparam logic [7:0] TYPE_LONG_B  = 8'hC4;
  localparam logic [7:0] RAW_CODE     = 8'hFF;

  localparam logic [15:0] HDR_SHORT = 16'd2;
  localparam logic [15:0] HDR_LONG  = 16'd3;

  localparam int unsigned FifoDepth = 3;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] packet_code;
    logic       first_of_packet;
    logic       last_of_packet;
    logic       empty_packet;
    logic       error_flag;
  } result_t;

  function automatic logic is_type(input logic [7:0] b);
    return (b == TYPE_SHORT_A) || (b == TYPE_LONG_A) ||
           (b == TYPE_SHORT_B) || (b == TYPE_LONG_B);
  endfunction

  function automatic logic is_long_type(input logic [7:0] b);
    return (b == TYPE_LONG_A) || (b == TYPE_LONG_B);
  endfunction

endpackage

### rtl/core/typed_length_prefix_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_length_prefix_deframer: split a byte stream into typed packets
// Header-typed, length-prefixed packet deframer with raw-run passthrough.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one transfer per byte. in_mode 0
//   carries in_data_byte; in_mode 1 is a flush that closes an open raw run.
//   Result channel (out_valid / out_stall): zero or one result per input
//   transfer, in order. Payload bytes carry their header type byte as
//   out_packet_code; raw-run bytes carry 0xFF. A header with no payload
//   gives one empty marker; a bad length gives one error result, after
//   which the block drops all input until reset.
//   Throughput: one input transfer per cycle, sustained, while the
//   receiver keeps up. A result passes the input register, then the
//   result queue, before it is offered. Raw bytes trail by one transfer,
//   since the last one must be marked.
//   Stall: a three-entry result queue decouples the sides; in_stall rises
//   only when queued plus in-flight results would fill it, so the result
//   channel's stall never reaches the input combinationally.
//   Reset (rst_n low, synchronous): empties the queue and the input
//   register and returns the parser to header search.
// ----------------------------------------------------------------------------
module typed_length_prefix_deframer
  import tlpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_byte,
  output logic [7:0] out_packet_code,
  output logic       out_first_of_packet,
  output logic       out_last_of_packet,
  output logic       out_empty_packet,
  output logic       out_error_flag
);

  logic                in_take;
  logic                stage_v;
  logic                push;
  result_t             res;
  logic                pop;
  result_t             head;
  logic [FifoCntW-1:0] q_count;
  logic [FifoCntW:0]   occupancy;

  // Count queued results plus the item in the input register
  assign occupancy = (FifoCntW + 1)'(q_count) + (FifoCntW + 1)'(stage_v);
  assign in_stall  = (occupancy >= (FifoCntW + 1)'(FifoDepth));
  assign in_take   = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  tlpd_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_take      (in_take),
    .in_mode      (in_mode),
    .in_data_byte (in_data_byte),
    .stage_v      (stage_v),
    .push         (push),
    .res          (res)
  );

  tlpd_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (res),
    .pop        (pop),
    .head_valid (out_valid),
    .head_data  (head),
    .count      (q_count)
  );

  assign out_out_byte        = head.out_byte;
  assign out_packet_code     = head.packet_code;
  assign out_first_of_packet = head.first_of_packet;
  assign out_last_of_packet  = head.last_of_packet;
  assign out_empty_packet    = head.empty_packet;
  assign out_error_flag      = head.error_flag;

  // Never push into a full queue that is not draining
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (q_count != FifoCntW'(FifoDepth)) || pop)
    else $error("result queue overflow");

  // An error result locks the parser: no further results
  a_error_lock: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.error_flag) |=> !push)
    else $error("result after error lock");

  // An empty marker is both first and last and carries no error
  a_empty_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.empty_packet) |->
      (res.first_of_packet && res.last_of_packet && !res.error_flag))
    else $error("malformed empty marker");

  // A result is pushed only for an item held in the input register
  a_push_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> stage_v)
    else $error("result without input item");

endmodule

### rtl/core/tlpd_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpd_parse: input register and deframing state machine
// Registers each accepted transfer, then decodes it in one pass against the
// header, length, payload and raw-run state, producing at most one result.
// ----------------------------------------------------------------------------
module tlpd_parse
  import tlpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_take,
  input  logic       in_mode,
  input  logic [7:0] in_data_byte,
  output logic       stage_v,
  output logic       push,
  output result_t    res
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LEN_ONE,
    PH_LEN_HIGH,
    PH_LEN_LOW,
    PH_DATA,
    PH_RAW,
    PH_ERROR
  } phase_t;

  logic        stage_v_r;
  logic        mode_r;
  logic [7:0]  byte_r;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  type_byte_r, type_byte_nxt;
  logic [7:0]  size_high_r, size_high_nxt;
  logic [15:0] payload_left_r, payload_left_nxt;
  logic        payload_first_r, payload_first_nxt;
  logic [7:0]  held_byte_r, held_byte_nxt;
  logic        held_first_r, held_first_nxt;

  logic [15:0] fin_total;
  logic [15:0] fin_hdr;

  // Input register: payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      mode_r <= in_mode;
      byte_r <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r       <= 1'b0;
      phase_r         <= PH_HEADER;
      type_byte_r     <= '0;
      size_high_r     <= '0;
      payload_left_r  <= '0;
      payload_first_r <= 1'b0;
      held_byte_r     <= '0;
      held_first_r    <= 1'b0;
    end else begin
      stage_v_r       <= in_take;
      phase_r         <= phase_nxt;
      type_byte_r     <= type_byte_nxt;
      size_high_r     <= size_high_nxt;
      payload_left_r  <= payload_left_nxt;
      payload_first_r <= payload_first_nxt;
      held_byte_r     <= held_byte_nxt;
      held_first_r    <= held_first_nxt;
    end
  end

  // Total length and header size for the length-closing phases
  assign fin_total = (phase_r == PH_LEN_LOW) ? {size_high_r, byte_r} : {8'h00, byte_r};
  assign fin_hdr   = (phase_r == PH_LEN_LOW) ? HDR_LONG : HDR_SHORT;

  always_comb begin
    phase_nxt         = phase_r;
    type_byte_nxt     = type_byte_r;
    size_high_nxt     = size_high_r;
    payload_left_nxt  = payload_left_r;
    payload_first_nxt = payload_first_r;
    held_byte_nxt     = held_byte_r;
    held_first_nxt    = held_first_r;
    push              = 1'b0;
    res               = '0;

    if (stage_v_r) begin
      if (phase_r == PH_RAW) begin
        // Release the held byte; close the run on flush or a type byte
        push                = 1'b1;
        res.out_byte        = held_byte_r;
        res.packet_code     = RAW_CODE;
        res.first_of_packet = held_first_r;
        held_first_nxt      = 1'b0;
        if (mode_r) begin
          res.last_of_packet = 1'b1;
          phase_nxt          = PH_HEADER;
        end else if (is_type(byte_r)) begin
          res.last_of_packet = 1'b1;
          type_byte_nxt      = byte_r;
          size_high_nxt      = '0;
          payload_left_nxt   = '0;
          phase_nxt          = is_long_type(byte_r) ? PH_LEN_HIGH : PH_LEN_ONE;
        end else begin
          held_byte_nxt = byte_r;
        end
      end else if (!mode_r) begin
        case (phase_r)
          PH_HEADER: begin
            if (is_type(byte_r)) begin
              type_byte_nxt    = byte_r;
              size_high_nxt    = '0;
              payload_left_nxt = '0;
              phase_nxt        = is_long_type(byte_r) ? PH_LEN_HIGH : PH_LEN_ONE;
            end else begin
              held_byte_nxt  = byte_r;
              held_first_nxt = 1'b1;
              phase_nxt      = PH_RAW;
            end
          end
          PH_LEN_HIGH: begin
            size_high_nxt = byte_r;
            phase_nxt     = PH_LEN_LOW;
          end
          PH_LEN_ONE, PH_LEN_LOW: begin
            if (fin_total == '0 || fin_total < fin_hdr) begin
              push           = 1'b1;
              res.error_flag = 1'b1;
              phase_nxt      = PH_ERROR;
            end else if (fin_total == fin_hdr) begin
              push                = 1'b1;
              res.packet_code     = type_byte_r;
              res.first_of_packet = 1'b1;
              res.last_of_packet  = 1'b1;
              res.empty_packet    = 1'b1;
              phase_nxt           = PH_HEADER;
            end else begin
              payload_left_nxt  = fin_total - fin_hdr;
              payload_first_nxt = 1'b1;
              phase_nxt         = PH_DATA;
            end
          end
          PH_DATA: begin
            push                = 1'b1;
            res.out_byte        = byte_r;
            res.packet_code     = type_byte_r;
            res.first_of_packet = payload_first_r;
            payload_first_nxt   = 1'b0;
            if (payload_left_r <= 16'd1) begin
              res.last_of_packet = 1'b1;
              payload_left_nxt   = '0;
              phase_nxt          = PH_HEADER;
            end else begin
              payload_left_nxt = payload_left_r - 16'd1;
            end
          end
          default: begin
            // error lock: drop everything
          end
        endcase
      end
    end
  end

  assign stage_v = stage_v_r;

endmodule

### rtl/core/tlpd_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpd_out_fifo: result queue
// Small register queue between the deframer and the result channel; the
// head entry holds steady while the receiver stalls.
// ----------------------------------------------------------------------------
module tlpd_out_fifo
  import tlpd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  result_t             push_data,
  input  logic                pop,
  output logic                head_valid,
  output result_t             head_data,
  output logic [FifoCntW-1:0] count
);

  result_t             ent_r [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FifoPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FifoCntW-1:0] cnt_r, cnt_nxt;

  localparam logic [FifoPtrW-1:0] LastIdx = FifoPtrW'(FifoDepth - 1);

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastIdx) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastIdx) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head_data  = ent_r[rd_ptr_r];
  assign count      = cnt_r;

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the typed length-prefix deframer
// Drives byte and flush transfers into the deframer with random gaps and
// random result-side back-pressure. A scoreboard tracks the parser state,
// predicts every delivered byte, empty marker and error result, and checks
// each result as it leaves the block.
// ----------------------------------------------------------------------------
module tb_top;
  import tlpd_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 11;
  localparam int RANDOM_ITEMS   = 1500;
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  // Parser position, as the deframer walks the stream.
  typedef enum logic [2:0] {
    SEEK_HEADER,
    READ_LEN_SHORT,
    READ_LEN_HIGH,
    READ_LEN_LOW,
    IN_PAYLOAD,
    IN_RAW,
    HALTED
  } parse_phase_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_mode;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_out_byte;
  logic [7:0] out_packet_code;
  logic       out_first_of_packet;
  logic       out_last_of_packet;
  logic       out_empty_packet;
  logic       out_error_flag;

  // Traffic shaping shared by the sender, the sink and the stimulus.
  bit tx_calm  = 1'b0;
  bit rx_calm  = 1'b0;
  bit hold_req = 1'b0;
  int sent_items = 0;
  int flushes    = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  typed_length_prefix_deframer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_out_byte       (out_out_byte),
    .out_packet_code    (out_packet_code),
    .out_first_of_packet(out_first_of_packet),
    .out_last_of_packet (out_last_of_packet),
    .out_empty_packet   (out_empty_packet),
    .out_error_flag     (out_error_flag)
  );

  // Header type codes occupy C1..C4; the even ones carry a two-byte length.
  function automatic bit is_header_code(logic [7:0] b);
    return (b >= 8'hC1) && (b <= 8'hC4);
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the parser and holds the deliveries still owed.
  // --------------------------------------------------------------------------
  class deframe_tracker_t;
    result_t      owed_results[$];
    parse_phase_t phase;
    logic [7:0]   code_seen;
    logic [7:0]   len_high;
    logic [7:0]   held_byte;
    logic [15:0]  bytes_left;
    bit           at_first;
    bit           held_first;
    int           mismatches;
    int           checked;
    int           packets;
    int           empties;
    int           raw_runs;

    function new();
      phase      = SEEK_HEADER;
      code_seen  = '0;
      len_high   = '0;
      held_byte  = '0;
      bytes_left = '0;
      at_first   = 1'b0;
      held_first = 1'b0;
      mismatches = 0;
      checked    = 0;
      packets    = 0;
      empties    = 0;
      raw_runs   = 0;
    endfunction

    function void owe(logic [7:0] b, logic [7:0] code, bit first, bit last,
                      bit empty, bit err);
      result_t r;
      r.out_byte        = b;
      r.packet_code     = code;
      r.first_of_packet = first;
      r.last_of_packet  = last;
      r.empty_packet    = empty;
      r.error_flag      = err;
      owed_results.push_back(r);
      if (last && code == RAW_CODE) raw_runs++;
      else if (last) packets++;
      if (empty) empties++;
    endfunction

    function void open_header(logic [7:0] b);
      code_seen  = b;
      len_high   = '0;
      bytes_left = '0;
      phase      = b[0] ? READ_LEN_SHORT : READ_LEN_HIGH;
    endfunction

    // Total length counts the header; zero or less than the header is fatal.
    function void close_length(logic [15:0] total, logic [15:0] hdr);
      if (total == 16'd0 || total < hdr) begin
        phase = HALTED;
        owe(8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
      end else if (total == hdr) begin
        phase = SEEK_HEADER;
        owe(8'h00, code_seen, 1'b1, 1'b1, 1'b1, 1'b0);
      end else begin
        bytes_left = total - hdr;
        at_first   = 1'b1;
        phase      = IN_PAYLOAD;
      end
    endfunction

    // Advance the parser by one accepted transfer.
    function void note_transfer(bit flush, logic [7:0] b);
      if (phase == IN_RAW) begin
        // Release the held byte; it is the last one if the run closes here.
        if (flush) begin
          owe(held_byte, RAW_CODE, held_first, 1'b1, 1'b0, 1'b0);
          held_first = 1'b0;
          phase      = SEEK_HEADER;
        end else if (is_header_code(b)) begin
          owe(held_byte, RAW_CODE, held_first, 1'b1, 1'b0, 1'b0);
          held_first = 1'b0;
          open_header(b);
        end else begin
          owe(held_byte, RAW_CODE, held_first, 1'b0, 1'b0, 1'b0);
          held_byte  = b;
          held_first = 1'b0;
        end
        return;
      end
      if (flush) return;
      case (phase)
        SEEK_HEADER: begin
          if (is_header_code(b)) begin
            open_header(b);
          end else begin
            held_byte  = b;
            held_first = 1'b1;
            phase      = IN_RAW;
          end
        end
        READ_LEN_SHORT: close_length({8'h00, b}, HDR_SHORT);
        READ_LEN_HIGH: begin
          len_high = b;
          phase    = READ_LEN_LOW;
        end
        READ_LEN_LOW: close_length({len_high, b}, HDR_LONG);
        IN_PAYLOAD: begin
          owe(b, code_seen, at_first, bytes_left <= 16'd1, 1'b0, 1'b0);
          at_first = 1'b0;
          if (bytes_left <= 16'd1) begin
            bytes_left = '0;
            phase      = SEEK_HEADER;
          end else begin
            bytes_left = bytes_left - 16'd1;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      checked++;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected result: byte %02h code %02h f%0b l%0b e%0b err%0b",
                   $time, got.out_byte, got.packet_code, got.first_of_packet,
                   got.last_of_packet, got.empty_packet, got.error_flag);
        return;
      end
      want = owed_results.pop_front();
      if (got.out_byte !== want.out_byte || got.packet_code !== want.packet_code ||
          got.first_of_packet !== want.first_of_packet ||
          got.last_of_packet !== want.last_of_packet ||
          got.empty_packet !== want.empty_packet || got.error_flag !== want.error_flag) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] result %0d mismatch", $time, checked);
          $display("  expected: byte %02h code %02h f%0b l%0b e%0b err%0b",
                   want.out_byte, want.packet_code, want.first_of_packet,
                   want.last_of_packet, want.empty_packet, want.error_flag);
          $display("  actual:   byte %02h code %02h f%0b l%0b e%0b err%0b",
                   got.out_byte, got.packet_code, got.first_of_packet,
                   got.last_of_packet, got.empty_packet, got.error_flag);
        end
      end
    endfunction
  endclass

  deframe_tracker_t sb = new();

  // Gap length for either side: mostly none, some short, a few long.
  function automatic int pick_pause(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Any byte but a header code, so a raw run keeps going.
  function automatic logic [7:0] pick_plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (is_header_code(b)) b = b ^ 8'h10;
    return b;
  endfunction

  // Offer one transfer after a random gap and hold it until accepted.
  // Valid is only lowered when a gap follows, so back-to-back items keep it high.
  task automatic send_item(bit mode, logic [7:0] b);
    int gap;
    gap = pick_pause(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_transfer(mode, b);
    sent_items++;
    if (mode) flushes++;
  endtask

  // Header, length and payload; stray flushes in between must be ignored.
  task automatic send_packet(logic [7:0] code, logic [15:0] total, int flush_pct);
    int n;
    send_item(1'b0, code);
    if ($urandom_range(0, 99) < flush_pct) send_item(1'b1, 8'($urandom_range(0, 255)));
    if (!code[0]) send_item(1'b0, total[15:8]);
    send_item(1'b0, total[7:0]);
    n = int'(total) - (code[0] ? 2 : 3);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < flush_pct) send_item(1'b1, 8'($urandom_range(0, 255)));
      // Header codes inside a payload are plain data.
      if ($urandom_range(0, 9) == 0) send_item(1'b0, 8'hC1 + 8'($urandom_range(0, 3)));
      else send_item(1'b0, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_raw_run(int n, bit close_flush);
    for (int i = 0; i < n; i++) send_item(1'b0, pick_plain_byte());
    if (close_flush) send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic random_packet();
    logic [7:0]  code;
    logic [15:0] total;
    int          r;
    case ($urandom_range(0, 3))
      0:       code = TYPE_SHORT_A;
      1:       code = TYPE_LONG_A;
      2:       code = TYPE_SHORT_B;
      default: code = TYPE_LONG_B;
    endcase
    r = $urandom_range(0, 99);
    // Mostly short; at times a long one, or 255 (short), 256..300 (long).
    if (code[0]) begin
      if (r < 88)      total = 16'($urandom_range(2, 20));
      else if (r < 97) total = 16'($urandom_range(21, 100));
      else             total = 16'd255;
    end else begin
      if (r < 88)      total = 16'($urandom_range(3, 24));
      else if (r < 97) total = 16'($urandom_range(25, 100));
      else             total = 16'($urandom_range(256, 300));
    end
    send_packet(code, total, 4);
  endtask

  // --------------------------------------------------------------------------
  // Result sink: check every transfer on the result side, then pick the
  // stall for the next cycle. Values sampled here are the pre-edge ones.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int      pause_left;
    result_t got;
    pause_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        got.out_byte        = out_out_byte;
        got.packet_code     = out_packet_code;
        got.first_of_packet = out_first_of_packet;
        got.last_of_packet  = out_last_of_packet;
        got.empty_packet    = out_empty_packet;
        got.error_flag      = out_error_flag;
        sb.check_result(got);
      end
      // A hold-off request forces a long stall counted here, so the
      // result queue fills and the block has to stall its input.
      if (hold_req) begin
        hold_req   = 1'b0;
        pause_left = HOLD_CYCLES;
      end
      if (pause_left > 0) begin
        out_stall <= 1'b1;
        pause_left--;
      end else begin
        out_stall <= 1'b0;
        pause_left = pick_pause(rx_calm);
      end
    end
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0))
        quiet = 0;
      else
        quiet++;
    end
    $display("Watchdog: no transfer for %0d cycles, %0d results still owed",
             WATCHDOG_LIMIT, sb.owed_results.size());
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int random_base;
    int r;
    bit pressed;
    bit bulk_done;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_mode      <= 1'b0;
    in_data_byte <= 8'h00;
    pressed    = 1'b0;
    bulk_done  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: flush while idle (dropped), empty markers of both header
    // sizes, a two-byte payload at the byte extremes, a one-byte payload, a
    // raw run closed by flush, a one-byte raw run closed by a header whose
    // payload is a header code, and a flush in the middle of a packet.
    send_item(1'b1, 8'hA5);
    send_item(1'b0, TYPE_SHORT_A);
    send_item(1'b0, 8'd2);
    send_item(1'b0, TYPE_LONG_A);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'd3);
    send_item(1'b0, TYPE_SHORT_B);
    send_item(1'b0, 8'd4);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, TYPE_LONG_B);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'd4);
    send_item(1'b0, 8'hAA);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h55);
    send_item(1'b1, 8'h5A);
    send_item(1'b0, 8'h7F);
    send_item(1'b0, TYPE_SHORT_A);
    send_item(1'b0, 8'd3);
    send_item(1'b0, TYPE_LONG_A);
    send_item(1'b0, TYPE_SHORT_B);
    send_item(1'b0, 8'd3);
    send_item(1'b1, 8'hFF);
    send_item(1'b0, 8'h12);

    // Random: mostly well-formed packets, then raw runs, then loose flushes.
    random_base = sent_items;
    while (sent_items - random_base < RANDOM_ITEMS) begin
      // Switch idling off on either side now and then, for a stretch.
      if ($urandom_range(0, 39) == 0) tx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 39) == 0) rx_calm = ($urandom_range(0, 3) == 0);

      if (!pressed && sent_items - random_base > 400) begin
        // Hold the result side off while the sender streams without gaps.
        pressed  = 1'b1;
        tx_calm  = 1'b1;
        hold_req = 1'b1;
        send_packet(TYPE_SHORT_B, 16'd120, 0);
        tx_calm  = 1'b0;
      end else if (!bulk_done && sent_items - random_base > 1000) begin
        // One packet whose total length needs a high length byte of one.
        bulk_done = 1'b1;
        send_packet(TYPE_LONG_B, 16'h01FF, 0);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60)      random_packet();
        else if (r < 85) send_raw_run($urandom_range(1, 8), $urandom_range(0, 1));
        else if (r < 95) send_item(1'b1, 8'($urandom_range(0, 255)));
        else             send_raw_run($urandom_range(20, 40), 1'b1);
      end
    end

    // Close with a bad length; the block must then drop everything.
    case ($urandom_range(0, 3))
      0: begin
        send_item(1'b0, TYPE_SHORT_A);
        send_item(1'b0, 8'd0);
      end
      1: begin
        send_item(1'b0, TYPE_SHORT_B);
        send_item(1'b0, 8'd1);
      end
      2: begin
        send_item(1'b0, TYPE_LONG_A);
        send_item(1'b0, 8'd0);
        send_item(1'b0, 8'd0);
      end
      default: begin
        send_item(1'b0, TYPE_LONG_B);
        send_item(1'b0, 8'd0);
        send_item(1'b0, 8'd2);
      end
    endcase
    repeat (16) begin
      if ($urandom_range(0, 3) == 0) send_item(1'b0, 8'hC1 + 8'($urandom_range(0, 3)));
      else send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
    in_valid <= 1'b0;

    // Drain, then give the pipeline time to show any stray result.
    rx_calm = 1'b1;
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d transfers (%0d flushes), %0d results checked, %0d mismatches",
             sent_items, flushes, sb.checked, sb.mismatches);
    $display("Summary: %0d packets (%0d empty), %0d raw runs, one bad-length halt",
             sb.packets, sb.empties, sb.raw_runs);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/tlpd_pkg.sv
rtl/core/tlpd_parse.sv
rtl/core/tlpd_out_fifo.sv
rtl/core/typed_length_prefix_deframer.sv
test/tb_top.sv
